// ----- hw/rtl/ethernet_ipv4_header_parser_unit_macros.svh -----
// Assertion macros for the Ethernet/IPv4 header parser.
`ifndef ETHERNET_IPV4_HEADER_PARSER_UNIT_MACROS_SVH
`define ETHERNET_IPV4_HEADER_PARSER_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define EIPHP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define EIPHP_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/eiphp_pkg.sv -----
// Shared types and constants for the Ethernet/IPv4 header parser.
package eiphp_pkg;

   localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;

   localparam logic [15:0] KIND_ARP  = 16'h0806;
   localparam logic [15:0] KIND_IPV4 = 16'h0800;
   localparam logic [7:0]  ARP_CODE  = 8'hFE;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   localparam logic [15:0] ETH_LEN   = 16'd14;
   localparam logic [15:0] ARP_BODY  = 16'd28;
   localparam logic [15:0] IPV4_MIN  = 16'd20;
   localparam logic [15:0] TCP_MIN   = 16'd20;
   localparam logic [15:0] UDP_MIN   = 16'd8;

   // Byte positions inside the frame
   localparam logic [15:0] POS_KIND_HI  = 16'd12;
   localparam logic [15:0] POS_KIND_LO  = 16'd13;
   localparam logic [15:0] POS_VER_IHL  = 16'd14;
   localparam logic [15:0] POS_PROTO    = 16'd23;
   localparam logic [15:0] POS_IP_SA    = 16'd26;
   localparam logic [15:0] POS_IP_DA    = 16'd30;
   localparam logic [15:0] POS_ARP_SA   = 16'd28;
   localparam logic [15:0] POS_ARP_DA   = 16'd38;

   localparam int          CSR_ADDR_W        = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAYLOAD_CAP = 3'd0;
   localparam logic [15:0] PAYLOAD_CAP_RESET = 16'd1500;

   // Per-frame collected header state
   typedef struct packed {
      logic [15:0] length;
      logic [15:0] kind;
      logic [3:0]  version;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] l4_sport;
      logic [15:0] l4_dport;
   } frame_state_type;

   // One summary result
   typedef struct packed {
      logic        accepted;
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] payload_length;
   } summary_type;

   // Offset of the transport header: 14 + IHL*4
   function automatic logic [15:0] port_base(input logic [3:0] ihl);
      port_base = ETH_LEN + {10'd0, ihl, 2'b00};
   endfunction

endpackage

// ----- hw/rtl/eiphp_byte_track.sv -----
// Per-byte header field capture for one frame at a time.
module eiphp_byte_track (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic [7:0]                 frame_byte,
   input  logic                       last_byte,
   output eiphp_pkg::frame_state_type frame_now
);

   eiphp_pkg::frame_state_type state_ff;
   eiphp_pkg::frame_state_type state_in;
   eiphp_pkg::frame_state_type upd;
   logic [15:0] p;
   logic [3:0]  ihl_eff;
   logic [15:0] t;

   always_comb begin
      upd     = state_ff;
      p       = state_ff.length;
      // IHL written on this very byte counts already
      ihl_eff = (p == eiphp_pkg::POS_VER_IHL) ? frame_byte[3:0] : state_ff.ihl;
      t       = eiphp_pkg::port_base(ihl_eff);
      if (state_ff.length != eiphp_pkg::MAX_FRAME_BYTES) begin
         upd.length = state_ff.length + 16'd1;
         if (p == eiphp_pkg::POS_KIND_HI) begin
            upd.kind = {frame_byte, 8'h00};
         end
         if (p == eiphp_pkg::POS_KIND_LO) begin
            upd.kind = {state_ff.kind[15:8], state_ff.kind[7:0] | frame_byte};
         end
         if (p >= eiphp_pkg::ETH_LEN) begin
            if (state_ff.kind == eiphp_pkg::KIND_ARP) begin
               if (p >= eiphp_pkg::POS_ARP_SA && p < eiphp_pkg::POS_ARP_SA + 16'd4) begin
                  upd.src_addr = {state_ff.src_addr[23:0], frame_byte};
               end
               if (p >= eiphp_pkg::POS_ARP_DA && p < eiphp_pkg::POS_ARP_DA + 16'd4) begin
                  upd.dst_addr = {state_ff.dst_addr[23:0], frame_byte};
               end
            end else if (state_ff.kind == eiphp_pkg::KIND_IPV4) begin
               if (p == eiphp_pkg::POS_VER_IHL) begin
                  upd.version = frame_byte[7:4];
                  upd.ihl     = frame_byte[3:0];
               end
               if (p == eiphp_pkg::POS_PROTO) begin
                  upd.proto = frame_byte;
               end
               if (p >= eiphp_pkg::POS_IP_SA && p < eiphp_pkg::POS_IP_SA + 16'd4) begin
                  upd.src_addr = {state_ff.src_addr[23:0], frame_byte};
               end
               if (p >= eiphp_pkg::POS_IP_DA && p < eiphp_pkg::POS_IP_DA + 16'd4) begin
                  upd.dst_addr = {state_ff.dst_addr[23:0], frame_byte};
               end
               if (p >= t && p < t + 16'd2) begin
                  upd.l4_sport = {state_ff.l4_sport[7:0], frame_byte};
               end
               if (p >= t + 16'd2 && p < t + 16'd4) begin
                  upd.l4_dport = {state_ff.l4_dport[7:0], frame_byte};
               end
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      if (take) begin
         state_in = last_byte ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign frame_now = upd;

endmodule

// ----- hw/rtl/eiphp_summary.sv -----
// Frame summary from collected header fields.
module eiphp_summary (
   input  eiphp_pkg::frame_state_type frame,
   input  logic [15:0]                payload_cap,
   output eiphp_pkg::summary_type     summary
);

   logic [15:0] len;
   logic [15:0] t;
   logic [15:0] need;
   logic [15:0] pay;
   logic        is_l4;
   logic        ok;
   eiphp_pkg::summary_type res;

   always_comb begin
      len   = frame.length;
      t     = eiphp_pkg::port_base(frame.ihl);
      is_l4 = (frame.proto == eiphp_pkg::PROTO_TCP) || (frame.proto == eiphp_pkg::PROTO_UDP);
      need  = (frame.proto == eiphp_pkg::PROTO_TCP) ? eiphp_pkg::TCP_MIN : eiphp_pkg::UDP_MIN;
      pay   = (t < len) ? (len - t) : 16'd0;
      if (pay > payload_cap) begin
         pay = payload_cap;
      end
      res = '0;
      ok  = 1'b0;
      if (len >= eiphp_pkg::ETH_LEN) begin
         if (frame.kind == eiphp_pkg::KIND_ARP) begin
            ok           = 1'b1;
            res.protocol = eiphp_pkg::ARP_CODE;
            if (len >= eiphp_pkg::ETH_LEN + eiphp_pkg::ARP_BODY) begin
               res.source_address = frame.src_addr;
               res.dest_address   = frame.dst_addr;
            end
         end else if (frame.kind == eiphp_pkg::KIND_IPV4 &&
                      len >= eiphp_pkg::ETH_LEN + eiphp_pkg::IPV4_MIN &&
                      frame.version == 4'd4) begin
            ok                 = 1'b1;
            res.protocol       = frame.proto;
            res.source_address = frame.src_addr;
            res.dest_address   = frame.dst_addr;
            res.payload_length = pay;
            if (is_l4) begin
               if (len >= t + need) begin
                  res.source_port = frame.l4_sport;
                  res.dest_port   = frame.l4_dport;
               end else begin
                  ok = 1'b0;
               end
            end
         end
      end
      if (!ok) begin
         res = '0;
      end
      res.accepted = ok;
   end

   assign summary = res;

endmodule

// ----- hw/rtl/ethernet_ipv4_header_parser_unit.sv -----
// A frame's last byte is held in the input register, then in the frame snapshot, before its summary is registered.
// Throughput: one byte per cycle while rsp is not back-pressured; summaries back to back, even for 1-byte frames.
// Stages: input register, header capture, frame snapshot, summary eval, output register.
// Reset: synchronous, active high; clears valids, frame state; payload_cap -> 1500.
// Back-pressure on rsp stalls req only when a last byte cannot move on.
// Top level of the Ethernet/IPv4 header parser.
`include "ethernet_ipv4_header_parser_unit_macros.svh"

module ethernet_ipv4_header_parser_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] frame_byte
   input  logic                             req_tlast,   // last_byte
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] protocol, [39:8] source_address, [71:40] dest_address,
   // [87:72] source_port, [103:88] dest_port, [119:104] payload_length
   output logic [119:0]                     rsp_tdata,
   output logic                             rsp_tuser,   // [0] accepted
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [eiphp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   // --- payload cap register ---
   logic [15:0] cap_ff, cap_in;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr && csr_paddr == eiphp_pkg::CSR_PAYLOAD_CAP) begin
         cap_in = csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr == eiphp_pkg::CSR_PAYLOAD_CAP) ? {16'd0, cap_ff} : 32'd0;

   // --- flow control ---
   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic in_last_ff, in_last_in;
   logic snap_valid_ff, snap_valid_in;
   eiphp_pkg::frame_state_type snap_ff, snap_in;
   logic rsp_valid_ff, rsp_valid_in;
   eiphp_pkg::summary_type rsp_ff, rsp_in;

   logic out_free, snap_free, in_go, out_load, req_take;
   eiphp_pkg::frame_state_type frame_now;
   eiphp_pkg::summary_type summary;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign out_load  = snap_valid_ff && out_free;
   assign snap_free = !snap_valid_ff || out_free;
   // non-last bytes only touch frame state and never wait
   assign in_go      = in_valid_ff && (!in_last_ff || snap_free);
   assign req_tready = !in_valid_ff || in_go;
   assign req_take   = req_tvalid && req_tready;

   eiphp_byte_track u_track (
      .clock      (clock),
      .reset      (reset),
      .take       (in_go),
      .frame_byte (in_byte_ff),
      .last_byte  (in_last_ff),
      .frame_now  (frame_now)
   );

   eiphp_summary u_summary (
      .frame       (snap_ff),
      .payload_cap (cap_ff),
      .summary     (summary)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end

      snap_valid_in = snap_valid_ff;
      snap_in       = snap_ff;
      if (in_go && in_last_ff) begin
         snap_valid_in = 1'b1;
         snap_in       = frame_now;
      end else if (out_load) begin
         snap_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = summary;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= eiphp_pkg::PAYLOAD_CAP_RESET;
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         in_valid_ff   <= in_valid_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      snap_ff    <= snap_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.accepted;
   assign rsp_tdata  = {rsp_ff.payload_length, rsp_ff.dest_port, rsp_ff.source_port,
                        rsp_ff.dest_address, rsp_ff.source_address, rsp_ff.protocol};

   // --- checks ---
   `EIPHP_ASSERT(a_reject_zero, (rsp_valid_ff && !rsp_ff.accepted) |-> (rsp_tdata == 120'd0), "rejected summary carries nonzero fields")
   `EIPHP_ASSERT(a_pay_capped, (rsp_valid_ff && rsp_ff.accepted) |-> (rsp_ff.payload_length <= cap_ff), "payload length above cap")
   `EIPHP_ASSERT(a_snap_kept, (snap_valid_ff && !out_free) |=> snap_valid_ff, "pending summary dropped")
   `EIPHP_ASSERT_NEVER(a_last_lost, in_valid_ff && in_last_ff && in_go && snap_valid_ff && !out_load, "last byte overwrote pending summary")

endmodule

// ----- sim/ethernet_ipv4_header_parser_checker.sv -----
// Checker: predicts frame summaries from the request stream and compares results.
`timescale 1ns / 100ps

module ethernet_ipv4_header_parser_checker
   import eiphp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [119:0]          rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic                  csr_pready,
   output int                    pending,
   output int                    failures
);

   // predicted copy of the register and the per-frame capture
   logic [15:0] cap;
   logic [15:0] frame_len;
   logic [15:0] kind;
   logic [3:0]  version;
   logic [3:0]  ihl;
   logic [7:0]  proto;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] l4_sport;
   logic [15:0] l4_dport;

   summary_type summaries_due[$];

   task automatic clear_frame();
      frame_len = '0;
      kind      = '0;
      version   = '0;
      ihl       = '0;
      proto     = '0;
      src_addr  = '0;
      dst_addr  = '0;
      l4_sport  = '0;
      l4_dport  = '0;
   endtask

   task automatic capture_byte(input int pos, input logic [7:0] b);
      int base;
      if (pos == POS_KIND_HI) kind = {b, 8'h00};
      if (pos == POS_KIND_LO) kind = {kind[15:8], b};
      if (pos < ETH_LEN) return;
      if (kind == KIND_ARP) begin
         if (pos >= POS_ARP_SA && pos < POS_ARP_SA + 4) src_addr = {src_addr[23:0], b};
         if (pos >= POS_ARP_DA && pos < POS_ARP_DA + 4) dst_addr = {dst_addr[23:0], b};
         return;
      end
      if (kind != KIND_IPV4) return;
      if (pos == POS_VER_IHL) begin
         version = b[7:4];
         ihl     = b[3:0];
      end
      if (pos == POS_PROTO) proto = b;
      if (pos >= POS_IP_SA && pos < POS_IP_SA + 4) src_addr = {src_addr[23:0], b};
      if (pos >= POS_IP_DA && pos < POS_IP_DA + 4) dst_addr = {dst_addr[23:0], b};
      // ihl is taken as is, so a small one puts the ports inside the IP header
      base = int'(ETH_LEN) + 4 * int'(ihl);
      if (pos >= base && pos < base + 2) l4_sport = {l4_sport[7:0], b};
      if (pos >= base + 2 && pos < base + 4) l4_dport = {l4_dport[7:0], b};
   endtask

   function automatic summary_type summarize_frame();
      summary_type s;
      int len, base, need, pay;
      s   = '0;
      len = int'(frame_len);
      if (len >= ETH_LEN) begin
         if (kind == KIND_ARP) begin
            s.accepted = 1'b1;
            s.protocol = ARP_CODE;
            if (len >= ETH_LEN + ARP_BODY) begin
               s.source_address = src_addr;
               s.dest_address   = dst_addr;
            end
         end else if (kind == KIND_IPV4 && len - int'(ETH_LEN) >= IPV4_MIN && version == 4'd4)
         begin
            s.accepted       = 1'b1;
            s.protocol       = proto;
            s.source_address = src_addr;
            s.dest_address   = dst_addr;
            base = int'(ETH_LEN) + 4 * int'(ihl);
            if (base < len) begin
               pay = len - base;
               if (pay > int'(cap)) pay = int'(cap);
               s.payload_length = pay[15:0];
            end
            if (proto == PROTO_TCP || proto == PROTO_UDP) begin
               need = (proto == PROTO_TCP) ? int'(TCP_MIN) : int'(UDP_MIN);
               if (len >= base + need) begin
                  s.source_port = l4_sport;
                  s.dest_port   = l4_dport;
               end else begin
                  s = '0;
               end
            end
         end
      end
      return s;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      summary_type want, got;
      if (reset) begin
         cap = PAYLOAD_CAP_RESET;
         clear_frame();
         summaries_due.delete();
         failures = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_PAYLOAD_CAP)
            cap = csr_pwdata[15:0];

         if (req_tvalid && req_tready) begin
            // bytes past the size limit are dropped, the length stays saturated
            if (frame_len != MAX_FRAME_BYTES) begin
               capture_byte(int'(frame_len), req_tdata);
               frame_len++;
            end
            if (req_tlast) begin
               summaries_due.push_back(summarize_frame());
               clear_frame();
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            got.accepted       = rsp_tuser;
            got.protocol       = rsp_tdata[7:0];
            got.source_address = rsp_tdata[39:8];
            got.dest_address   = rsp_tdata[71:40];
            got.source_port    = rsp_tdata[87:72];
            got.dest_port      = rsp_tdata[103:88];
            got.payload_length = rsp_tdata[119:104];
            if (summaries_due.size() == 0) begin
               $error("summary 0x%0h with no frame outstanding", got);
               failures++;
            end else begin
               want = summaries_due.pop_front();
               check_field("accepted", 32'(want.accepted), 32'(got.accepted));
               check_field("protocol", 32'(want.protocol), 32'(got.protocol));
               check_field("source_address", want.source_address, got.source_address);
               check_field("dest_address", want.dest_address, got.dest_address);
               check_field("source_port", 32'(want.source_port), 32'(got.source_port));
               check_field("dest_port", 32'(want.dest_port), 32'(got.dest_port));
               check_field("payload_length", 32'(want.payload_length),
                           32'(got.payload_length));
            end
         end
      end
      pending <= summaries_due.size();
   end

endmodule

// ----- sim/tb.sv -----
// Testbench top: drives frames and register writes into the header parser.
`timescale 1ns / 100ps

module tb;
   import eiphp_pkg::*;

   // run is cut off here
   localparam int CYCLE_LIMIT = 2_000_000;
   // pipeline is 3 deep; give it some slack before touching the register
   localparam int DRAIN_CYCLES = 12;
   // address of a register slot that does not exist
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 3'd4;
   localparam logic [7:0] PROTO_ICMP = 8'd1;

   typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_mode_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [119:0]          rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int pending;
   int failures;
   int cycles = 0;

   // sender burst bookkeeping
   int burst_left = 0;

   // receiver stall pattern plus the one long hold-off
   int          hold_left  = 0;
   int          mode_left  = 0;
   rx_mode_type stall_mode = RX_STEADY;
   logic        squeeze    = 1'b0;
   logic        squeezed   = 1'b0;

   // frame under construction, wire order
   logic [7:0] frame[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ethernet_ipv4_header_parser_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ethernet_ipv4_header_parser_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .pending     (pending),
      .failures    (failures)
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: picks a new stall mode each time its mode count runs out. When the
   // stimulus raises squeeze it holds tready low for a long stretch once,
   // so results back up and the block has to push back on requests.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (squeeze && !squeezed) begin
         hold_left  <= 400;
         squeezed   <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left  <= $urandom_range(16, 128);
            stall_mode <= rx_mode_type'($urandom_range(0, 2));
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            RX_STEADY: rsp_tready <= 1'b1;
            RX_LIGHT:  rsp_tready <= ($urandom_range(0, 3) != 0);
            default:   rsp_tready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   // One request. Entered and left at a falling edge. A burst runs with
   // tvalid held high; between bursts the sender may idle with tvalid low.
   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         // mostly short bursts, now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_frame();
      foreach (frame[i]) push_byte(frame[i], i == frame.size() - 1);
   endtask

   task automatic fill_frame(input int len);
      frame.delete();
      repeat (len) frame.push_back(8'($urandom));
   endtask

   // set a header byte only if the frame reaches that far
   function automatic void put(input int pos, input logic [7:0] v);
      if (pos < frame.size()) frame[pos] = v;
   endfunction

   task automatic make_ipv4(input int len, input logic [3:0] ver, input logic [3:0] ihl,
                            input logic [7:0] proto);
      fill_frame(len);
      put(POS_KIND_HI, KIND_IPV4[15:8]);
      put(POS_KIND_LO, KIND_IPV4[7:0]);
      put(POS_VER_IHL, {ver, ihl});
      put(POS_PROTO, proto);
   endtask

   task automatic make_arp(input int len);
      fill_frame(len);
      put(POS_KIND_HI, KIND_ARP[15:8]);
      put(POS_KIND_LO, KIND_ARP[7:0]);
   endtask

   // Register writes only with the block idle: stop sending, wait for every
   // summary, then give the pipeline time to settle.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_cap(input logic [15:0] cap);
      // junk in the upper half must be ignored
      write_csr(CSR_PAYLOAD_CAP, {16'($urandom), cap});
   endtask

   task automatic random_cap();
      case ($urandom_range(0, 4))
         0:       set_cap(16'd0);
         1:       set_cap(16'hFFFF);
         2:       set_cap(16'($urandom_range(1, 64)));
         3:       set_cap(PAYLOAD_CAP_RESET);
         default: set_cap(16'($urandom));
      endcase
   endtask

   // Mostly IPv4, largely TCP/UDP so the port and payload logic gets exercised,
   // some with odd IHL or version or truncated; the rest is ARP, foreign EtherTypes and runts.
   task automatic random_frame();
      int         pick, base, need, len;
      logic [3:0] ihl, ver;
      logic [7:0] proto;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
         ver = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd4;
         case ($urandom_range(0, 3))
            0:       proto = PROTO_TCP;
            1, 3:    proto = PROTO_UDP;
            default: proto = 8'($urandom);
         endcase
         need = (proto == PROTO_TCP) ? int'(TCP_MIN) : (proto == PROTO_UDP) ? int'(UDP_MIN) : 0;
         base = int'(ETH_LEN) + 4 * int'(ihl);
         len  = base + need;
         if (len < ETH_LEN + IPV4_MIN) len = ETH_LEN + IPV4_MIN;
         if ($urandom_range(0, 5) == 0) len = $urandom_range(ETH_LEN, len + 4);
         else len = len + $urandom_range(0, 48);
         make_ipv4(len, ver, ihl, proto);
      end else if (pick < 80) begin
         make_arp($urandom_range(14, 70));
      end else if (pick < 90) begin
         fill_frame($urandom_range(14, 60));
      end else begin
         fill_frame($urandom_range(1, 13));
      end
      send_frame();
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed frames, register at its reset value ---
      fill_frame(1);                              // runt of one byte
      send_frame();
      make_ipv4(13, 4'd4, 4'd5, PROTO_TCP);       // one byte short of an Ethernet header
      send_frame();
      fill_frame(14);                             // bare Ethernet header, EtherType 0
      foreach (frame[i]) frame[i] = 8'h00;
      send_frame();
      make_arp(14);                               // Ethernet header only, ARP EtherType, no addresses
      send_frame();
      make_arp(41);                               // one byte short of the ARP body
      send_frame();
      make_arp(42);
      send_frame();
      make_ipv4(33, 4'd4, 4'd5, PROTO_ICMP);      // IPv4 header cut short
      send_frame();
      make_ipv4(34, 4'd4, 4'd5, PROTO_ICMP);      // bare IP header, no payload
      send_frame();
      make_ipv4(34, 4'd6, 4'd5, PROTO_ICMP);      // wrong version
      send_frame();
      make_ipv4(53, 4'd4, 4'd5, PROTO_TCP);       // TCP header truncated
      send_frame();
      make_ipv4(41, 4'd4, 4'd5, PROTO_UDP);       // UDP header truncated
      send_frame();
      make_ipv4(34, 4'd4, 4'd0, PROTO_UDP);       // IHL 0: ports overlap version byte
      send_frame();
      make_ipv4(36, 4'd4, 4'd1, PROTO_UDP);       // IHL 1
      send_frame();
      make_ipv4(40, 4'd4, 4'd15, PROTO_ICMP);     // IP header runs past the frame end
      send_frame();

      // --- back-pressure: long receiver hold-off over a run of tiny frames ---
      squeeze <= 1'b1;
      repeat (16) push_byte(8'($urandom), 1'b1);

      // --- payload cap extremes ---
      set_cap(16'd0);
      make_ipv4(42, 4'd4, 4'd5, PROTO_UDP);       // UDP header exactly fits
      send_frame();
      set_cap(16'hFFFF);
      make_ipv4(54, 4'd4, 4'd5, PROTO_TCP);       // TCP header exactly fits
      send_frame();
      set_cap(16'd7);
      make_ipv4(60, 4'd4, 4'd5, PROTO_UDP);
      send_frame();
      // write to a slot that does not exist; cap must stay at 7
      write_csr(CSR_SPARE, 32'hFFFF_FFFF);
      make_ipv4(34, 4'd4, 4'd5, PROTO_ICMP);
      send_frame();

      // --- two random frames under a random cap ---
      random_cap();
      repeat (2) random_frame();

      // --- drain ---
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
